// File: src/tbde_pkg.sv
// Package for the three-band delay enhancer: constants, request types and helpers.
// It has no dependencies. The top-level module and its memories use it.
package tbde_pkg;

  localparam int ENHANCE_DEPTH_DEF = 256;
  localparam int DOUBLER_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS       = 16;
  localparam int SINE_TABLE_SIZE   = 256;
  localparam int SINE_BITS         = 8;
  localparam int ADDR_W            = 5;

  localparam int BASE_TAP     = 32;
  localparam int ALPHA_LOW    = 679;
  localparam int ALPHA_UP     = 27720;
  localparam int ALPHA_TONE   = 19347;
  localparam int GAIN_CONTOUR = 72090;
  localparam int GAIN_MID     = 68813;
  localparam int MIX_DRY      = 57672;
  localparam int MIX_SAME     = 10486;
  localparam int MIX_CROSS    = 5243;
  localparam int DLY_BASE_L   = 620;
  localparam int DLY_BASE_R   = 870;
  localparam int DLY_MOD_L    = 70;
  localparam int DLY_MOD_R    = 96;

  localparam logic [23:0] PHASE_INC_L   = 24'd129;
  localparam logic [23:0] PHASE_INC_R   = 24'd185;
  localparam logic [23:0] PHASE_START_R = 24'd5200937;

  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598671;
  localparam logic [63:0] SIN_C5 = 64'd85569278;
  localparam logic [63:0] SIN_C7 = 64'd5027044;
  localparam logic [63:0] SIN_C9 = 64'd172271;

  localparam logic [2:0] REG_CONTOUR  = 3'd0;
  localparam logic [2:0] REG_PROCESS  = 3'd1;
  localparam logic [2:0] REG_MIDRANGE = 3'd2;
  localparam logic [2:0] REG_BYPASS   = 3'd3;
  localparam logic [2:0] REG_DOUBLER  = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } out_req_t;

  typedef logic signed [15:0] sine_tab_t [SINE_TABLE_SIZE];

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic sine_tab_t sine_build();
    sine_tab_t   t;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [1:0]  quad;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      a    = 64'(i) << (24 - SINE_BITS);
      quad = a[23:22];
      r    = a & 64'h3F_FFFF;
      if (quad[0]) begin
        r = 64'h40_0000 - r;
      end
      x  = r << 8;
      x2 = (x * x) >> 30;
      p  = SIN_C9;
      p  = SIN_C7 - ((x2 * p) >> 30);
      p  = SIN_C5 - ((x2 * p) >> 30);
      p  = SIN_C3 - ((x2 * p) >> 30);
      p  = SIN_C1 - ((x2 * p) >> 30);
      s  = ((x * p) >> 30) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      t[i] = quad[1] ? -$signed(16'(s)) : $signed(16'(s));
    end
    return t;
  endfunction

endpackage

// File: src/three_band_delay_enhancer.sv
// Top level of the three-band delay enhancer with its optional stereo doubler.
// Depends on tbde_pkg; holds the band and doubler delay memories.
//
// Each channel runs FL, FU, WB, C1-C4 and EN, then with the doubler on V0-V9 and
// M0-M3; a bypassed request goes straight to OUT. A new request is accepted once
// the previous one has left the datapath, even while its result still waits at the
// output. The pace is set by the single shared multiplier, which every filter, gain,
// interpolation and mix product passes through one cycle at a time, and by the
// single read port of each delay memory. The delay memories need no clearing pass:
// fill flags make entries not yet written since reset or a clear read as zero.
module three_band_delay_enhancer #(
  parameter int ENHANCE_DEPTH = tbde_pkg::ENHANCE_DEPTH_DEF,
  parameter int DOUBLER_DEPTH = tbde_pkg::DOUBLER_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tbde_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tbde_pkg::out_req_t          out_req_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbde_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tbde_pkg::*;

  localparam int EAW = $clog2(ENHANCE_DEPTH);
  localparam int EMW = $clog2(2 * ENHANCE_DEPTH);
  localparam int DAW = $clog2(DOUBLER_DEPTH);
  localparam int RW  = DAW + 18;

  localparam logic signed [RW-1:0] SPAN_S = RW'(DOUBLER_DEPTH) << 16;
  localparam logic signed [RW-1:0] OFFS_L = SPAN_S - (RW'(DLY_BASE_L) << 16);
  localparam logic signed [RW-1:0] OFFS_R = SPAN_S - (RW'(DLY_BASE_R) << 16);
  localparam sine_tab_t SINE_TAB = sine_build();

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FL   = 5'd1;
  localparam logic [4:0] S_FU   = 5'd2;
  localparam logic [4:0] S_WB   = 5'd3;
  localparam logic [4:0] S_C1   = 5'd4;
  localparam logic [4:0] S_C2   = 5'd5;
  localparam logic [4:0] S_C3   = 5'd6;
  localparam logic [4:0] S_C4   = 5'd7;
  localparam logic [4:0] S_EN   = 5'd8;
  localparam logic [4:0] S_V0   = 5'd9;
  localparam logic [4:0] S_V1   = 5'd10;
  localparam logic [4:0] S_V2   = 5'd11;
  localparam logic [4:0] S_V3   = 5'd12;
  localparam logic [4:0] S_V4   = 5'd13;
  localparam logic [4:0] S_V5   = 5'd14;
  localparam logic [4:0] S_V6   = 5'd15;
  localparam logic [4:0] S_V7   = 5'd16;
  localparam logic [4:0] S_V8   = 5'd17;
  localparam logic [4:0] S_V9   = 5'd18;
  localparam logic [4:0] S_M0   = 5'd19;
  localparam logic [4:0] S_M1   = 5'd20;
  localparam logic [4:0] S_M2   = 5'd21;
  localparam logic [4:0] S_M3   = 5'd22;
  localparam logic [4:0] S_OUT  = 5'd23;

  logic [4:0]  state_q;
  logic        ch_q;
  logic [10:0] contour_q, process_q, midrange_q;
  logic        bypass_q, dben_q;

  logic [EAW-1:0] dl_q, dm_q, dh_q;
  logic [16:0]    gc_q, gm_q, gp_q;

  logic signed [31:0] lf_q [2];
  logic signed [31:0] uf_q [2];
  logic signed [23:0] tone_q [2];
  logic [23:0]        phase_q [2];
  logic [EAW-1:0]     enh_ptr_q;
  logic               enh_full_q;
  logic [DAW-1:0]     dptr_q;
  logic               dfull_q;

  logic signed [15:0] x_q [2];
  logic [71:0]        base_q;
  logic signed [17:0] tl_q, tm_q, th_q;
  logic signed [51:0] prod_q, acc_q;
  logic signed [23:0] e_q [2];
  logic signed [23:0] o_q [2];
  logic signed [RW-1:0] rp_q;
  logic [DAW-1:0]     i0_q;
  logic [15:0]        f_q;
  logic signed [15:0] va_q, vb_q;
  logic signed [16:0] vce_q;
  out_req_t           out_q;
  logic               out_valid_q;

  logic [71:0]        emem [2 * ENHANCE_DEPTH];
  logic [71:0]        erdata_q;
  logic               evalid_q;
  logic [15:0]        dmem_l [DOUBLER_DEPTH];
  logic [15:0]        dmem_r [DOUBLER_DEPTH];
  logic [15:0]        drdata_l_q, drdata_r_q;
  logic               dvalid_q;

  logic        cfg_we;
  logic [10:0] c_k, p_k, m_k;
  logic [10:0] dl_n, dh_n, dm_n, dm_off;

  logic [EAW-1:0] rd_d;
  logic [EAW:0]   tdiff;
  logic [EAW-1:0] tidx;
  logic [EMW-1:0] eraddr, ewaddr;
  logic           evld;
  logic [71:0]    erd, ewdata;
  logic           ewe;
  logic signed [17:0] b_dry, b_low, b_mid, b_high;
  logic signed [15:0] x_cur;
  logic signed [15:0] lo_v, up_v;
  logic signed [23:0] e_n;

  logic [DAW-1:0] i1, draddr;
  logic           dvld;
  logic signed [15:0] drd;
  logic signed [RW-1:0] rp_w;
  logic signed [15:0] sine_cur;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;

  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite && pready;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    unique case (paddr[4:2])
      REG_CONTOUR:  prdata = 32'(contour_q);
      REG_PROCESS:  prdata = 32'(process_q);
      REG_MIDRANGE: prdata = 32'(midrange_q);
      REG_BYPASS:   prdata = 32'(bypass_q);
      REG_DOUBLER:  prdata = 32'(dben_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    c_k  = (contour_q > 11'd1024) ? 11'd1024 : contour_q;
    p_k  = (process_q > 11'd1024) ? 11'd1024 : process_q;
    m_k  = (midrange_q > 11'd1024) ? 11'd1024 : midrange_q;
    dl_n = 11'(BASE_TAP) + 11'((12'(c_k) + 12'd8) >> 4);
    if (dl_n > 11'(ENHANCE_DEPTH - 1)) begin
      dl_n = 11'(ENHANCE_DEPTH - 1);
    end
    dh_n = 11'(BASE_TAP) - 11'((12'(p_k) + 12'd64) >> 7);
    if (m_k <= 11'd512) begin
      dm_off = 11'((12'(11'd512 - m_k) * 12'd3) >> 7);
      dm_n   = 11'(BASE_TAP) + dm_off;
    end else begin
      dm_off = 11'((12'(m_k - 11'd512) * 12'd3) >> 7);
      dm_n   = 11'(BASE_TAP) - dm_off;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= EAW'(dl_n);
    dm_q <= EAW'(dm_n);
    dh_q <= EAW'(dh_n);
    gc_q <= 17'((28'(GAIN_CONTOUR) * 28'(c_k)) >> 10);
    gm_q <= 17'((28'(GAIN_MID) * 28'(m_k)) >> 10);
    gp_q <= 17'(p_k) << 6;
  end

  // Band delay memory: one word holds the dry, low, mid and high samples.
  assign x_cur = x_q[ch_q];
  assign lo_v  = lf_q[ch_q][31:16];
  assign up_v  = uf_q[ch_q][31:16];
  assign ewe   = (state_q == S_C1);
  assign ewdata = {18'(x_cur), 18'(lo_v), 18'(18'(up_v) - 18'(lo_v)),
                   18'(18'(x_cur) - 18'(up_v))};
  assign ewaddr = ch_q ? EMW'(enh_ptr_q) + EMW'(ENHANCE_DEPTH) : EMW'(enh_ptr_q);

  always_comb begin
    case (state_q)
      S_FL:    rd_d = EAW'(BASE_TAP);
      S_FU:    rd_d = dl_q;
      S_WB:    rd_d = dm_q;
      default: rd_d = dh_q;
    endcase
    tdiff  = {1'b0, enh_ptr_q} - {1'b0, rd_d};
    tidx   = tdiff[EAW] ? EAW'(tdiff + (EAW+1)'(ENHANCE_DEPTH)) : tdiff[EAW-1:0];
    eraddr = ch_q ? EMW'(tidx) + EMW'(ENHANCE_DEPTH) : EMW'(tidx);
    evld   = enh_full_q || (tidx < enh_ptr_q);
  end

  always_ff @(posedge clk_i) begin
    if (ewe) begin
      emem[ewaddr] <= ewdata;
    end
    erdata_q <= emem[eraddr];
  end

  assign erd    = evalid_q ? erdata_q : '0;
  assign b_dry  = $signed(base_q[71:54]);
  assign b_low  = $signed(base_q[53:36]);
  assign b_mid  = $signed(base_q[35:18]);
  assign b_high = $signed(base_q[17:0]);
  assign e_n    = 24'(b_dry) + 24'(acc_q >>> 16);

  // Doubler memories: one line per channel, written together.
  assign i1     = (i0_q == DAW'(DOUBLER_DEPTH - 1)) ? '0 : i0_q + 1'b1;
  assign draddr = (state_q == S_V3) ? i0_q : i1;
  assign dvld   = dfull_q || (draddr < dptr_q);
  assign drd    = dvalid_q ? $signed(ch_q ? drdata_r_q : drdata_l_q) : 16'sd0;
  assign rp_w   = (rp_q >= SPAN_S) ? rp_q - SPAN_S : rp_q;
  assign sine_cur = SINE_TAB[phase_q[ch_q][23 -: SINE_BITS]];

  always_ff @(posedge clk_i) begin
    if (state_q == S_V0 && !ch_q) begin
      dmem_l[dptr_q] <= sat16(e_q[0]);
      dmem_r[dptr_q] <= sat16(e_q[1]);
    end
    drdata_l_q <= dmem_l[draddr];
    drdata_r_q <= dmem_r[draddr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_FL: begin
        mul_a = (34'(x_cur) <<< 16) - 34'(lf_q[ch_q]);
        mul_b = 18'(ALPHA_LOW);
      end
      S_FU: begin
        mul_a = (34'(x_cur) <<< 16) - 34'(uf_q[ch_q]);
        mul_b = 18'(ALPHA_UP);
      end
      S_C1: begin
        mul_a = 34'(tl_q) - 34'(b_low);
        mul_b = $signed({1'b0, gc_q});
      end
      S_C2: begin
        mul_a = 34'(tm_q) - 34'(b_mid);
        mul_b = $signed({1'b0, gm_q});
      end
      S_C3: begin
        mul_a = 34'(th_q) - 34'(b_high);
        mul_b = $signed({1'b0, gp_q});
      end
      S_V0: begin
        mul_a = 34'(sine_cur);
        mul_b = ch_q ? 18'(DLY_MOD_R) : 18'(DLY_MOD_L);
      end
      S_V5: begin
        mul_a = 34'(va_q);
        mul_b = $signed({1'b0, 17'(17'd65536 - 17'(f_q))});
      end
      S_V6: begin
        mul_a = 34'(vb_q);
        mul_b = $signed({2'b0, f_q});
      end
      S_V8: begin
        mul_a = (34'(vce_q) <<< 8) - 34'(tone_q[ch_q]);
        mul_b = 18'(ALPHA_TONE);
      end
      S_M0: begin
        mul_a = 34'(e_q[ch_q]) <<< 8;
        mul_b = 18'(MIX_DRY);
      end
      S_M1: begin
        mul_a = 34'(tone_q[ch_q]);
        mul_b = 18'(MIX_SAME);
      end
      S_M2: begin
        mul_a = 34'(tone_q[!ch_q]);
        mul_b = 18'(MIX_CROSS);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_q[0] <= in_req_i.sample_left;
          x_q[1] <= in_req_i.sample_right;
          o_q[0] <= 24'(in_req_i.sample_left);
          o_q[1] <= 24'(in_req_i.sample_right);
        end
      end
      S_FU: base_q <= erd;
      S_WB: tl_q <= $signed(erd[53:36]);
      S_C1: tm_q <= $signed(erd[35:18]);
      S_C2: begin
        th_q  <= $signed(erd[17:0]);
        acc_q <= prod_q;
      end
      S_C3: acc_q <= acc_q + prod_q;
      S_C4: acc_q <= acc_q + prod_q;
      S_EN: begin
        e_q[ch_q] <= e_n;
        if (ch_q && !dben_q) begin
          o_q[0] <= e_q[0];
          o_q[1] <= e_n;
        end
      end
      S_V1: rp_q <= RW'({dptr_q, 16'b0}) + (ch_q ? OFFS_R : OFFS_L) - RW'(prod_q);
      S_V2: begin
        i0_q <= rp_w[DAW+15:16];
        f_q  <= rp_w[15:0];
      end
      S_V4: va_q <= drd;
      S_V5: vb_q <= drd;
      S_V6: acc_q <= prod_q;
      S_V7: vce_q <= 17'((acc_q + prod_q) >>> 16);
      S_M1: acc_q <= prod_q;
      S_M2: acc_q <= acc_q + prod_q;
      S_M3: o_q[ch_q] <= 24'((acc_q + prod_q) >>> 24);
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_q <= '{out_left: sat16(o_q[0]), out_right: sat16(o_q[1])};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      evalid_q    <= 1'b0;
      dvalid_q    <= 1'b0;
      contour_q   <= 11'd461;
      process_q   <= 11'd461;
      midrange_q  <= 11'd512;
      bypass_q    <= 1'b0;
      dben_q      <= 1'b0;
      lf_q[0]     <= '0;
      lf_q[1]     <= '0;
      uf_q[0]     <= '0;
      uf_q[1]     <= '0;
      tone_q[0]   <= '0;
      tone_q[1]   <= '0;
      phase_q[0]  <= '0;
      phase_q[1]  <= PHASE_START_R;
      enh_ptr_q   <= '0;
      enh_full_q  <= 1'b0;
      dptr_q      <= '0;
      dfull_q     <= 1'b0;
    end else begin
      evalid_q <= evld;
      dvalid_q <= dvld;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            ch_q    <= 1'b0;
            state_q <= bypass_q ? S_OUT : S_FL;
          end
        end
        S_FL: state_q <= S_FU;
        S_FU: begin
          lf_q[ch_q] <= lf_q[ch_q] + 32'(prod_q >>> 16);
          state_q    <= S_WB;
        end
        S_WB: begin
          uf_q[ch_q] <= uf_q[ch_q] + 32'(prod_q >>> 16);
          state_q    <= S_C1;
        end
        S_C1: state_q <= S_C2;
        S_C2: state_q <= S_C3;
        S_C3: state_q <= S_C4;
        S_C4: state_q <= S_EN;
        S_EN: begin
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= S_FL;
          end else begin
            ch_q    <= 1'b0;
            state_q <= dben_q ? S_V0 : S_OUT;
          end
        end
        S_V0: state_q <= S_V1;
        S_V1: state_q <= S_V2;
        S_V2: state_q <= S_V3;
        S_V3: state_q <= S_V4;
        S_V4: state_q <= S_V5;
        S_V5: state_q <= S_V6;
        S_V6: state_q <= S_V7;
        S_V7: state_q <= S_V8;
        S_V8: state_q <= S_V9;
        S_V9: begin
          tone_q[ch_q] <= tone_q[ch_q] + 24'(prod_q >>> 16);
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= S_V0;
          end else begin
            ch_q    <= 1'b0;
            state_q <= S_M0;
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: state_q <= S_M3;
        S_M3: begin
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= S_M0;
          end else begin
            ch_q    <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (!bypass_q) begin
              if (enh_ptr_q == EAW'(ENHANCE_DEPTH - 1)) begin
                enh_ptr_q  <= '0;
                enh_full_q <= 1'b1;
              end else begin
                enh_ptr_q <= enh_ptr_q + 1'b1;
              end
              if (dben_q) begin
                if (dptr_q == DAW'(DOUBLER_DEPTH - 1)) begin
                  dptr_q  <= '0;
                  dfull_q <= 1'b1;
                end else begin
                  dptr_q <= dptr_q + 1'b1;
                end
                phase_q[0] <= phase_q[0] + PHASE_INC_L;
                phase_q[1] <= phase_q[1] + PHASE_INC_R;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_we) begin
        unique case (paddr[4:2])
          REG_CONTOUR:  contour_q  <= pwdata[10:0];
          REG_PROCESS:  process_q  <= pwdata[10:0];
          REG_MIDRANGE: midrange_q <= pwdata[10:0];
          REG_BYPASS: begin
            bypass_q <= pwdata[0];
            if (!pwdata[0]) begin
              lf_q[0]    <= '0;
              lf_q[1]    <= '0;
              uf_q[0]    <= '0;
              uf_q[1]    <= '0;
              enh_ptr_q  <= '0;
              enh_full_q <= 1'b0;
              tone_q[0]  <= '0;
              tone_q[1]  <= '0;
              phase_q[0] <= '0;
              phase_q[1] <= PHASE_START_R;
              dptr_q     <= '0;
              dfull_q    <= 1'b0;
            end
          end
          REG_DOUBLER: begin
            dben_q     <= pwdata[0];
            tone_q[0]  <= '0;
            tone_q[1]  <= '0;
            phase_q[0] <= '0;
            phase_q[1] <= PHASE_START_R;
            dptr_q     <= '0;
            dfull_q    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule
